FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion macros used by the top-level rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define SAPC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define SAPC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: rtl/sapc_pkg.sv
// ----------------------------------------------------------------------------
// sapc_pkg
// shared widths, codes and types of the smoothed adc press classifier
// ----------------------------------------------------------------------------
package sapc_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int COUNT_BITS  = 16;
    localparam int SUM_BITS    = SAMPLE_BITS + 4;
    localparam int ADDR_BITS   = 4;
    localparam int DATA_BITS   = 32;

    localparam logic [SAMPLE_BITS-1:0] RELEASE_THRESHOLD_RESET = SAMPLE_BITS'(300);
    localparam logic [SAMPLE_BITS-1:0] PRESS_THRESHOLD_RESET   = SAMPLE_BITS'(700);
    localparam logic [COUNT_BITS-1:0]  LONG_PRESS_COUNT_RESET  = COUNT_BITS'(20);
    localparam logic [COUNT_BITS-1:0]  SHORT_PRESS_COUNT_RESET = COUNT_BITS'(5);
    localparam logic [COUNT_BITS-1:0]  COUNT_MAX               = '1;

    typedef enum logic [1:0] {
        PRESS_NONE  = 2'd0,
        PRESS_SHORT = 2'd1,
        PRESS_LONG  = 2'd2
    } press_t;

    typedef enum logic [1:0] {
        REG_RELEASE_THRESHOLD = 2'd0,
        REG_PRESS_THRESHOLD   = 2'd1,
        REG_LONG_PRESS_COUNT  = 2'd2,
        REG_SHORT_PRESS_COUNT = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] release_threshold;
        logic [SAMPLE_BITS-1:0] press_threshold;
        logic [COUNT_BITS-1:0]  long_press_count;
        logic [COUNT_BITS-1:0]  short_press_count;
    } cfg_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] battery_average;
        logic [SAMPLE_BITS-1:0] button_average;
        press_t                 press_event;
        press_t                 press_state;
    } result_t;

endpackage

FILE: rtl/sapc_sample_if.sv
// ----------------------------------------------------------------------------
// sapc_sample_if
// valid/ready channel carrying one pair of raw adc samples per transfer
// ----------------------------------------------------------------------------
interface sapc_sample_if
    import sapc_pkg::*;
    ();
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] battery_sample;
    logic [SAMPLE_BITS-1:0] button_sample;

    modport source (output valid, output battery_sample, output button_sample, input ready);
    modport sink   (input valid, input battery_sample, input button_sample, output ready);
endinterface

FILE: rtl/sapc_result_if.sv
// ----------------------------------------------------------------------------
// sapc_result_if
// valid/ready channel carrying one classification result per transfer
// ----------------------------------------------------------------------------
interface sapc_result_if
    import sapc_pkg::*;
    ();
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] battery_average;
    logic [SAMPLE_BITS-1:0] button_average;
    logic [1:0]             press_event;
    logic [1:0]             press_state;

    modport source (output valid, output battery_average, output button_average,
                    output press_event, output press_state, input ready);
    modport sink   (input valid, input battery_average, input button_average,
                    input press_event, input press_state, output ready);
endinterface

FILE: rtl/sapc_regs.sv
// ----------------------------------------------------------------------------
// sapc_regs
// apb configuration registers: thresholds and press counts
// ----------------------------------------------------------------------------
module sapc_regs
    import sapc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready,
    output cfg_t                 cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t reg_idx;
    logic     write_en;

    assign reg_idx  = reg_idx_t'(paddr[ADDR_BITS-1:2]);
    assign write_en = psel && penable && pwrite;
    assign pready   = 1'b1;
    assign cfg      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (write_en)
        begin
            case (reg_idx)
                REG_RELEASE_THRESHOLD: cfg_next.release_threshold = pwdata[SAMPLE_BITS-1:0];
                REG_PRESS_THRESHOLD:   cfg_next.press_threshold   = pwdata[SAMPLE_BITS-1:0];
                REG_LONG_PRESS_COUNT:  cfg_next.long_press_count  = pwdata[COUNT_BITS-1:0];
                REG_SHORT_PRESS_COUNT: cfg_next.short_press_count = pwdata[COUNT_BITS-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_RELEASE_THRESHOLD: prdata = DATA_BITS'(cfg_reg.release_threshold);
            REG_PRESS_THRESHOLD:   prdata = DATA_BITS'(cfg_reg.press_threshold);
            REG_LONG_PRESS_COUNT:  prdata = DATA_BITS'(cfg_reg.long_press_count);
            REG_SHORT_PRESS_COUNT: prdata = DATA_BITS'(cfg_reg.short_press_count);
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.release_threshold <= RELEASE_THRESHOLD_RESET;
            cfg_reg.press_threshold   <= PRESS_THRESHOLD_RESET;
            cfg_reg.long_press_count  <= LONG_PRESS_COUNT_RESET;
            cfg_reg.short_press_count <= SHORT_PRESS_COUNT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/sapc_step.sv
// ----------------------------------------------------------------------------
// sapc_step
// filter and press counter state with one registered update per sample pair
// ----------------------------------------------------------------------------
module sapc_step
    import sapc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step_en,
    input  logic [SAMPLE_BITS-1:0] battery_sample,
    input  logic [SAMPLE_BITS-1:0] button_sample,
    input  cfg_t                   cfg,
    output result_t                result
);

    logic [SAMPLE_BITS-1:0] battery_filter_reg;
    logic [SAMPLE_BITS-1:0] battery_filter_next;
    logic [SAMPLE_BITS-1:0] button_filter_reg;
    logic [SAMPLE_BITS-1:0] button_filter_next;
    logic [COUNT_BITS-1:0]  press_counter_reg;
    logic [COUNT_BITS-1:0]  press_counter_next;
    press_t                 latched_press_reg;
    press_t                 latched_press_next;
    press_t                 press_event;
    logic [SUM_BITS-1:0]    battery_sum;
    logic [SUM_BITS-1:0]    button_sum;
    logic                   released;
    logic                   pressed;

    // avg*15 as avg*16 - avg
    assign battery_sum = SUM_BITS'(battery_sample)
                       + ({battery_filter_reg, 4'b0000} - SUM_BITS'(battery_filter_reg));
    assign button_sum  = SUM_BITS'(button_sample)
                       + ({button_filter_reg, 4'b0000} - SUM_BITS'(button_filter_reg));

    assign battery_filter_next = battery_sum[SUM_BITS-1:4];
    assign button_filter_next  = button_sum[SUM_BITS-1:4];

    assign released = button_filter_next < cfg.release_threshold;
    assign pressed  = button_filter_next > cfg.press_threshold;

    always_comb
    begin
        press_event        = PRESS_NONE;
        press_counter_next = press_counter_reg;
        latched_press_next = latched_press_reg;
        if (released)
        begin
            // long match takes precedence over short
            if (press_counter_reg == cfg.long_press_count)
            begin
                press_event = PRESS_LONG;
            end
            else if (press_counter_reg == cfg.short_press_count)
            begin
                press_event = PRESS_SHORT;
            end
            if (press_event != PRESS_NONE)
            begin
                latched_press_next = press_event;
                press_counter_next = '0;
            end
            else if (press_counter_reg != '0)
            begin
                press_counter_next = press_counter_reg - COUNT_BITS'(1);
            end
        end
        else if (pressed)
        begin
            if (press_counter_reg != COUNT_MAX)
            begin
                press_counter_next = press_counter_reg + COUNT_BITS'(1);
            end
        end
    end

    assign result.battery_average = battery_filter_next;
    assign result.button_average  = button_filter_next;
    assign result.press_event     = press_event;
    assign result.press_state     = latched_press_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            battery_filter_reg <= '0;
            button_filter_reg  <= '0;
            press_counter_reg  <= '0;
            latched_press_reg  <= PRESS_NONE;
        end
        else if (step_en)
        begin
            battery_filter_reg <= battery_filter_next;
            button_filter_reg  <= button_filter_next;
            press_counter_reg  <= press_counter_next;
            latched_press_reg  <= latched_press_next;
        end
    end

endmodule

FILE: rtl/smoothed_adc_press_classifier.sv
// ----------------------------------------------------------------------------
// smoothed_adc_press_classifier
// smooths battery and button adc samples and classifies short/long presses
// ----------------------------------------------------------------------------
// usage
//   sample_ch takes one battery/button sample pair per transfer, result_ch
//   gives exactly one result per sample pair, in order: both smoothed
//   averages, the press event of this tick and the latched press state.
//   the apb port holds release/press thresholds and long/short press counts
//   at byte addresses 0, 4, 8, 12; write only while no result is pending.
// timing
//   a sample pair sits in an input register and is processed into the
//   result register once that is empty or being taken by result_ch; the
//   single filter and counter update lies between the two registers. one
//   transfer per cycle is sustained while result_ch.ready stays high.
// reset
//   filters, press counter and latched state clear to zero, the registers
//   take their default values, both channels come up empty.
// stall
//   while result_ch is stalled the input register still takes one more
//   sample pair; sample_ch.ready drops only when both registers are full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module smoothed_adc_press_classifier
    import sapc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready,
    sapc_sample_if.sink          sample_ch,
    sapc_result_if.source        result_ch
);

    cfg_t                   cfg;
    result_t                step_result;
    logic                   in_valid_reg;
    logic                   in_valid_next;
    logic [SAMPLE_BITS-1:0] in_battery_reg;
    logic [SAMPLE_BITS-1:0] in_button_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    result_t                result_reg;
    logic                   advance;
    logic                   step_en;
    logic                   sample_transfer;

    sapc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sapc_step u_step (
        .clk            (clk),
        .rst_n          (rst_n),
        .step_en        (step_en),
        .battery_sample (in_battery_reg),
        .button_sample  (in_button_reg),
        .cfg            (cfg),
        .result         (step_result)
    );

    assign advance         = !out_valid_reg || result_ch.ready;
    assign step_en         = in_valid_reg && advance;
    assign sample_ch.ready = !in_valid_reg || advance;
    assign sample_transfer = sample_ch.valid && sample_ch.ready;

    assign in_valid_next  = sample_transfer || (in_valid_reg && !step_en);
    assign out_valid_next = step_en || (out_valid_reg && !result_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_transfer)
        begin
            in_battery_reg <= sample_ch.battery_sample;
            in_button_reg  <= sample_ch.button_sample;
        end
        if (step_en)
        begin
            result_reg <= step_result;
        end
    end

    assign result_ch.valid           = out_valid_reg;
    assign result_ch.battery_average = result_reg.battery_average;
    assign result_ch.button_average  = result_reg.button_average;
    assign result_ch.press_event     = result_reg.press_event;
    assign result_ch.press_state     = result_reg.press_state;

    // a press event is always the state just latched
    `SAPC_ASSERT_IMP(a_event_latched,
        out_valid_reg && result_reg.press_event != PRESS_NONE,
        result_reg.press_state == result_reg.press_event,
        "press event differs from latched state")

    // events only happen on a released button level
    `SAPC_ASSERT_IMP(a_event_released,
        out_valid_reg && result_reg.press_event != PRESS_NONE,
        result_reg.button_average < cfg.release_threshold,
        "press event without release")

    // sample channel only backs up when both registers are full
    `SAPC_ASSERT_IMP(a_stall_full,
        !sample_ch.ready,
        in_valid_reg && out_valid_reg && !result_ch.ready,
        "sample channel stalled with free space")

    // a processed pair always lands in the result register
    `SAPC_ASSERT(a_step_result,
        step_en |=> out_valid_reg,
        "processed sample pair lost")

endmodule
